// ----- hdl/spbu_pkg.sv -----
// Package for the sweep-and-prune box update unit.
// Holds field widths, default sizes and event codes; depends on nothing.
package spbu_pkg;

   localparam int DEF_NUM_BOXES  = 8;
   localparam int DEF_COORD_BITS = 16;

   localparam int IN_BOX_W   = 3;
   localparam int IN_COORD_W = 16;
   localparam int SPLIT_W    = 4;
   localparam int KIND_W     = 2;
   localparam int MAX_EVENTS = 48;
   localparam int EVCNT_W    = $clog2(MAX_EVENTS + 1);

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type EV_NONE   = 2'd0;
   localparam kind_type EV_ADD    = 2'd1;
   localparam kind_type EV_REMOVE = 2'd2;

endpackage

// ----- hdl/spbu_mem.sv -----
// Synchronous memory with one write and one registered read port.
// Each entry has a valid bit cleared by reset; no package dependencies.
module spbu_mem #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   output logic                     rd_valid
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// ----- hdl/sweep_prune_box_update_unit.sv -----
// Sweep-and-prune box update unit: moves one box's six endpoints through the sorted axes.
// An endpoint that keeps its value is only read and compared; one that moves is found by a scan
// of the order from its start and then swapped past each neighbour it passes; a neighbour of
// the other group may add an overlap test of up to six bounds and an event; one item at a time.
// The walk is set by the single read port of the memories, and a held result beat stalls it.
// Reset is synchronous. Depends on spbu_pkg and spbu_mem.
module sweep_prune_box_update_unit #(
   parameter int NUM_BOXES  = spbu_pkg::DEF_NUM_BOXES,
   parameter int COORD_BITS = spbu_pkg::DEF_COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [spbu_pkg::SPLIT_W-1:0]      csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [spbu_pkg::IN_BOX_W-1:0]     req_box_index,
   input  logic [spbu_pkg::IN_COORD_W-1:0]   req_min_x,
   input  logic [spbu_pkg::IN_COORD_W-1:0]   req_min_y,
   input  logic [spbu_pkg::IN_COORD_W-1:0]   req_min_z,
   input  logic [spbu_pkg::IN_COORD_W-1:0]   req_max_x,
   input  logic [spbu_pkg::IN_COORD_W-1:0]   req_max_y,
   input  logic [spbu_pkg::IN_COORD_W-1:0]   req_max_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [spbu_pkg::KIND_W-1:0]       rsp_event_kind,
   output logic [spbu_pkg::IN_BOX_W-1:0]     rsp_low_box,
   output logic [spbu_pkg::IN_BOX_W-1:0]     rsp_high_box,
   output logic                              rsp_last
);
   import spbu_pkg::*;

   localparam int BOX_W = $clog2(NUM_BOXES);
   localparam int EP_W  = BOX_W + 1;
   localparam int NE    = 2 * NUM_BOXES;
   localparam int DEPTH = 3 * NE;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RDOLD  = 4'd1;
   localparam logic [3:0] ST_CHKOLD = 4'd2;
   localparam logic [3:0] ST_FIND   = 4'd3;
   localparam logic [3:0] ST_WRD    = 4'd4;
   localparam logic [3:0] ST_WCRD   = 4'd5;
   localparam logic [3:0] ST_WCMP   = 4'd6;
   localparam logic [3:0] ST_SWAP2  = 4'd7;
   localparam logic [3:0] ST_OVRD   = 4'd8;
   localparam logic [3:0] ST_OVCK   = 4'd9;
   localparam logic [3:0] ST_EVT    = 4'd10;
   localparam logic [3:0] ST_NEXT   = 4'd11;
   localparam logic [3:0] ST_FIN    = 4'd12;

   localparam logic [EP_W-1:0] LAST_POS = EP_W'(NE - 1);

   function automatic logic [AW-1:0] mem_addr(input logic [1:0] axis,
                                              input logic [EP_W-1:0] idx);
      mem_addr = AW'(AW'(axis) * AW'(NE)) + AW'(idx);
   endfunction

   function automatic logic is_group_one(input logic [BOX_W-1:0] box,
                                         input logic [SPLIT_W-1:0] split);
      is_group_one = !(8'(box) < 8'(split));
   endfunction

   logic [3:0]                    state_ff, state_in;
   logic [SPLIT_W-1:0]            split_ff;
   logic [BOX_W-1:0]              box_ff, box_in;
   logic signed [COORD_BITS-1:0]  lo_ff [3];
   logic signed [COORD_BITS-1:0]  hi_ff [3];
   logic [1:0]                    axis_ff, axis_in;
   logic                          ismax_ff, ismax_in;
   logic                          down_ff, down_in;
   logic [EP_W-1:0]               pos_ff, pos_in;
   logic [EP_W-1:0]               cep_ff, cep_in;
   logic [EP_W-1:0]               oidx_ff, oidx_in;
   logic [2:0]                    k_ff, k_in;
   logic [NUM_BOXES-1:0]          pair_ff [NUM_BOXES];
   logic                          pair_wr, pair_val;
   kind_type                      evk_ff, evk_in;
   logic                          pend_v_ff, pend_v_in;
   kind_type                      pend_k_ff, pend_k_in;
   logic [BOX_W-1:0]              pend_l_ff, pend_l_in, pend_h_ff, pend_h_in;
   logic [EVCNT_W-1:0]            cnt_ff, cnt_in;
   logic                          rsp_v_ff, rsp_v_in;
   kind_type                      rsp_k_ff, rsp_k_in;
   logic [BOX_W-1:0]              rsp_l_ff, rsp_l_in, rsp_h_ff, rsp_h_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          c_wr_en, c_rd_en, c_rd_valid;
   logic [AW-1:0]                 c_wr_addr, c_rd_addr;
   logic [COORD_BITS-1:0]         c_wr_data, c_rd_data;
   logic                          o_wr_en, o_rd_en, o_rd_valid;
   logic [AW-1:0]                 o_wr_addr, o_rd_addr;
   logic [EP_W-1:0]               o_wr_data, o_rd_data;

   logic signed [COORD_BITS-1:0]  coord_rd, limit;
   logic [EP_W-1:0]               order_rd, ep, np;
   logic [BOX_W-1:0]              oth, pl, ph;
   logic                          out_free, at_end, relevant, is_add, fail;

   spbu_mem #(.WIDTH(COORD_BITS), .DEPTH(DEPTH)) u_coord_mem (
      .clock(clock), .reset(reset),
      .wr_en(c_wr_en), .wr_addr(c_wr_addr), .wr_data(c_wr_data),
      .rd_en(c_rd_en), .rd_addr(c_rd_addr),
      .rd_data(c_rd_data), .rd_valid(c_rd_valid)
   );

   spbu_mem #(.WIDTH(EP_W), .DEPTH(DEPTH)) u_order_mem (
      .clock(clock), .reset(reset),
      .wr_en(o_wr_en), .wr_addr(o_wr_addr), .wr_data(o_wr_data),
      .rd_en(o_rd_en), .rd_addr(o_rd_addr),
      .rd_data(o_rd_data), .rd_valid(o_rd_valid)
   );

   assign coord_rd = c_rd_valid ? $signed(c_rd_data) : '0;
   assign order_rd = o_rd_valid ? o_rd_data : oidx_ff;
   assign ep       = {box_ff, ismax_ff};
   assign np       = down_ff ? pos_ff - 1'b1 : pos_ff + 1'b1;
   assign limit    = ismax_ff ? hi_ff[axis_ff] : lo_ff[axis_ff];
   assign oth      = cep_ff[EP_W-1:1];
   assign pl       = (box_ff < oth) ? box_ff : oth;
   assign ph       = (box_ff < oth) ? oth : box_ff;
   assign pair_val = pair_ff[pl][ph];
   assign out_free = !rsp_v_ff || !rsp_stall;
   assign at_end   = down_ff ? (pos_ff == '0) : (pos_ff == LAST_POS);
   assign relevant = (cep_ff[0] != ismax_ff) &&
                     (is_group_one(oth, split_ff) != is_group_one(box_ff, split_ff));
   assign is_add   = ismax_ff != down_ff;
   assign fail     = k_ff[0] ? (coord_rd < lo_ff[k_ff[2:1]]) : (hi_ff[k_ff[2:1]] < coord_rd);

   always_comb begin
      state_in    = state_ff;
      box_in      = box_ff;
      axis_in     = axis_ff;
      ismax_in    = ismax_ff;
      down_in     = down_ff;
      pos_in      = pos_ff;
      cep_in      = cep_ff;
      oidx_in     = oidx_ff;
      k_in        = k_ff;
      evk_in      = evk_ff;
      pair_wr     = 1'b0;
      pend_v_in   = pend_v_ff;
      pend_k_in   = pend_k_ff;
      pend_l_in   = pend_l_ff;
      pend_h_in   = pend_h_ff;
      cnt_in      = cnt_ff;
      rsp_v_in    = rsp_v_ff && rsp_stall;
      rsp_k_in    = rsp_k_ff;
      rsp_l_in    = rsp_l_ff;
      rsp_h_in    = rsp_h_ff;
      rsp_last_in = rsp_last_ff;
      c_wr_en     = 1'b0;
      c_wr_addr   = mem_addr(axis_ff, ep);
      c_wr_data   = limit;
      c_rd_en     = 1'b0;
      c_rd_addr   = mem_addr(axis_ff, ep);
      o_wr_en     = 1'b0;
      o_wr_addr   = mem_addr(axis_ff, np);
      o_wr_data   = ep;
      o_rd_en     = 1'b0;
      o_rd_addr   = mem_addr(axis_ff, np);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               box_in   = BOX_W'(req_box_index);
               axis_in  = 2'd0;
               ismax_in = 1'b0;
               state_in = (32'(req_box_index) < 32'(NUM_BOXES)) ? ST_RDOLD : ST_FIN;
            end
         end
         ST_RDOLD: begin
            c_rd_en  = 1'b1;
            state_in = ST_CHKOLD;
         end
         ST_CHKOLD: begin
            if (coord_rd == limit) begin
               state_in = ST_NEXT;
            end else begin
               c_wr_en   = 1'b1;
               down_in   = limit < coord_rd;
               pos_in    = '0;
               oidx_in   = '0;
               o_rd_en   = 1'b1;
               o_rd_addr = mem_addr(axis_ff, '0);
               state_in  = ST_FIND;
            end
         end
         ST_FIND: begin
            if (order_rd == ep || pos_ff == LAST_POS) begin
               state_in = ST_WRD;
            end else begin
               pos_in    = pos_ff + 1'b1;
               oidx_in   = pos_ff + 1'b1;
               o_rd_en   = 1'b1;
               o_rd_addr = mem_addr(axis_ff, pos_ff + 1'b1);
            end
         end
         ST_WRD: begin
            if (at_end) begin
               state_in = ST_NEXT;
            end else begin
               o_rd_en  = 1'b1;
               oidx_in  = np;
               state_in = ST_WCRD;
            end
         end
         ST_WCRD: begin
            cep_in    = order_rd;
            c_rd_en   = 1'b1;
            c_rd_addr = mem_addr(axis_ff, order_rd);
            state_in  = ST_WCMP;
         end
         ST_WCMP: begin
            if (down_ff ? (coord_rd > limit) : (coord_rd < limit)) begin
               o_wr_en  = 1'b1;
               state_in = ST_SWAP2;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_SWAP2: begin
            o_wr_en   = 1'b1;
            o_wr_addr = mem_addr(axis_ff, pos_ff);
            o_wr_data = cep_ff;
            pos_in    = np;
            state_in  = ST_WRD;
            if (relevant) begin
               if (!is_add && pair_val) begin
                  pair_wr  = 1'b1;
                  evk_in   = EV_REMOVE;
                  state_in = ST_EVT;
               end else if (is_add && !pair_val) begin
                  k_in     = 3'd0;
                  state_in = ST_OVRD;
               end
            end
         end
         ST_OVRD: begin
            c_rd_en   = 1'b1;
            c_rd_addr = mem_addr(k_ff[2:1], {oth, k_ff[0]});
            state_in  = ST_OVCK;
         end
         ST_OVCK: begin
            if (fail) begin
               state_in = ST_WRD;
            end else if (k_ff == 3'd5) begin
               pair_wr  = 1'b1;
               evk_in   = EV_ADD;
               state_in = ST_EVT;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_OVRD;
            end
         end
         ST_EVT: begin
            if (cnt_ff == EVCNT_W'(MAX_EVENTS)) begin
               state_in = ST_WRD;
            end else if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  rsp_v_in    = 1'b1;
                  rsp_k_in    = pend_k_ff;
                  rsp_l_in    = pend_l_ff;
                  rsp_h_in    = pend_h_ff;
                  rsp_last_in = 1'b0;
               end
               pend_v_in = 1'b1;
               pend_k_in = evk_ff;
               pend_l_in = pl;
               pend_h_in = ph;
               cnt_in    = cnt_ff + 1'b1;
               state_in  = ST_WRD;
            end
         end
         ST_NEXT: begin
            state_in = ST_RDOLD;
            if (!ismax_ff) begin
               ismax_in = 1'b1;
            end else if (axis_ff != 2'd2) begin
               axis_in  = axis_ff + 1'b1;
               ismax_in = 1'b0;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_v_in    = 1'b1;
               rsp_k_in    = pend_v_ff ? pend_k_ff : EV_NONE;
               rsp_l_in    = pend_v_ff ? pend_l_ff : '0;
               rsp_h_in    = pend_v_ff ? pend_h_ff : '0;
               rsp_last_in = 1'b1;
               pend_v_in   = 1'b0;
               cnt_in      = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         split_ff  <= SPLIT_W'(4);
         pend_v_ff <= 1'b0;
         cnt_ff    <= '0;
         rsp_v_ff  <= 1'b0;
         for (int i = 0; i < NUM_BOXES; i++) begin
            pair_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         pend_v_ff <= pend_v_in;
         cnt_ff    <= cnt_in;
         rsp_v_ff  <= rsp_v_in;
         if (csr_write_enable) begin
            split_ff <= csr_write_data;
         end
         if (pair_wr) begin
            pair_ff[pl][ph] <= !pair_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      box_ff      <= box_in;
      axis_ff     <= axis_in;
      ismax_ff    <= ismax_in;
      down_ff     <= down_in;
      pos_ff      <= pos_in;
      cep_ff      <= cep_in;
      oidx_ff     <= oidx_in;
      k_ff        <= k_in;
      evk_ff      <= evk_in;
      pend_k_ff   <= pend_k_in;
      pend_l_ff   <= pend_l_in;
      pend_h_ff   <= pend_h_in;
      rsp_k_ff    <= rsp_k_in;
      rsp_l_ff    <= rsp_l_in;
      rsp_h_ff    <= rsp_h_in;
      rsp_last_ff <= rsp_last_in;
      if (state_ff == ST_IDLE && req_valid) begin
         lo_ff[0] <= $signed(COORD_BITS'(req_min_x));
         lo_ff[1] <= $signed(COORD_BITS'(req_min_y));
         lo_ff[2] <= $signed(COORD_BITS'(req_min_z));
         hi_ff[0] <= $signed(COORD_BITS'(req_max_x));
         hi_ff[1] <= $signed(COORD_BITS'(req_max_y));
         hi_ff[2] <= $signed(COORD_BITS'(req_max_z));
      end
   end

   assign req_stall      = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_v_ff;
   assign rsp_event_kind = rsp_k_ff;
   assign rsp_low_box    = IN_BOX_W'(rsp_l_ff);
   assign rsp_high_box   = IN_BOX_W'(rsp_h_ff);
   assign rsp_last       = rsp_last_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block did not leave idle after taking a beat");

   a_pend_counted: assert property (@(posedge clock) disable iff (reset)
      pend_v_ff |-> cnt_ff != '0)
      else $error("pending event without a count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= EVCNT_W'(MAX_EVENTS))
      else $error("event count beyond limit");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_v_ff && cnt_ff == '0)
      else $error("idle with an event still pending");

endmodule
